// ===== rtl/id_to_slot_hash_index_top_assert.svh =====
// Assertion macros for the id to slot hash index block.
`ifndef ID_TO_SLOT_HASH_INDEX_TOP_ASSERT_SVH
`define ID_TO_SLOT_HASH_INDEX_TOP_ASSERT_SVH

// same-cycle implication
`define ITHI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define ITHI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/ithi_pkg.sv =====
// Types and constants shared by the id to slot hash index block.
package ithi_pkg;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] task_id;
      logic [6:0]  record_slot;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [6:0] found_index;
   } rsp_type;

   typedef struct packed {
      logic        go;
      logic [63:0] key;
   } hash_req_type;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_INSERT,
      OP_REMOVE,
      OP_REBIND
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FAIL,
      ST_HASH,
      ST_RD_SLOT,
      ST_RD_REC,
      ST_EVAL,
      ST_RB_RD,
      ST_RB_CHK
   } state_type;

endpackage

// ===== rtl/ithi_home.sv =====
// Home slot unit: key modulo the slot count.
module ithi_home #(
   parameter int SLOTS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ithi_pkg::hash_req_type      hreq,
   output logic                        done,
   output logic [$clog2(SLOTS)-1:0]    home
);
   import ithi_pkg::*;

   localparam int SW = $clog2(SLOTS);

   generate
      if ((1 << SW) == SLOTS) begin : g_mask
         logic          done_ff;
         logic [SW-1:0] home_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= hreq.go;
            end
         end
         always_ff @(posedge clock) begin
            if (hreq.go) begin
               home_ff <= hreq.key[SW-1:0];
            end
         end
         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_radix
         // four key bits per cycle, remainder digit picked by parallel compares
         logic          run_ff;
         logic          done_ff;
         logic [3:0]    cnt_ff;
         logic [63:0]   sh_ff;
         logic [SW-1:0] rem_ff;
         logic [SW+3:0] acc;
         logic [SW+3:0] acc_red;
         always_comb begin
            acc     = {rem_ff, sh_ff[63:60]};
            acc_red = acc;
            for (int q = 1; q < 16; q++) begin
               if (acc >= (SW+4)'(q * SLOTS)) begin
                  acc_red = acc - (SW+4)'(q * SLOTS);
               end
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= run_ff && (cnt_ff == 4'd15);
               if (hreq.go) begin
                  run_ff <= 1'b1;
                  cnt_ff <= '0;
               end else if (run_ff) begin
                  cnt_ff <= cnt_ff + 4'd1;
                  if (cnt_ff == 4'd15) begin
                     run_ff <= 1'b0;
                  end
               end
            end
         end
         always_ff @(posedge clock) begin
            if (hreq.go) begin
               sh_ff  <= hreq.key;
               rem_ff <= '0;
            end else if (run_ff) begin
               sh_ff  <= {sh_ff[59:0], 4'd0};
               rem_ff <= acc_red[SW-1:0];
            end
         end
         assign done = done_ff;
         assign home = rem_ff;
      end
   endgenerate

endmodule

// ===== rtl/id_to_slot_hash_index_top.sv =====
// Top level: id to record index hash table with linear probing.
// One command is taken when start is high and busy is low; exactly one
// result beat follows on rsp_valid for a single cycle and cannot be held
// off. Each probe reads the slot memory and then the record memory in
// turn. With a slot count that is not a power of two the home slot is
// found in the radix-16 remainder unit. After reset a clearing pass over
// both memories runs with busy high. A removal that empties the table
// keeps busy high for a clear of the slot memory; one that triggers a
// rebuild runs that clear and then a rehash of every stored record but
// the removed one.
`include "id_to_slot_hash_index_top_assert.svh"
module id_to_slot_hash_index_top #(
   parameter int SLOTS   = 256,
   parameter int RECORDS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ithi_pkg::req_type req_item,
   output logic              rsp_valid,
   output ithi_pkg::rsp_type rsp_item
);
   import ithi_pkg::*;

   localparam int SW    = $clog2(SLOTS);
   localparam int RW    = $clog2(RECORDS);
   localparam int CW    = $clog2(RECORDS + 2);
   localparam int NW    = $clog2(SLOTS + 1);
   localparam int CLR_N = (SLOTS > RECORDS) ? SLOTS : RECORDS;
   localparam int CLW   = $clog2(CLR_N);
   localparam int QUARTER = (SLOTS + 3) / 4;
   localparam logic [CW-1:0] CODE_EMPTY = '0;
   localparam logic [CW-1:0] CODE_TOMB  = '1;

   logic [CW-1:0] slot_mem [SLOTS];
   logic [63:0]   rec_mem  [RECORDS];

   state_type state_ff, state_in;
   op_type    op_ff;
   logic [CLW-1:0] clr_idx_ff;
   logic           clr_rec_ff, clr_to_rb_ff;
   logic [NW-1:0]  live_ff, tomb_ff;
   logic [63:0]    key_ff, retired_ff;
   logic [RW-1:0]  code_ff, rb_idx_ff;
   logic [SW-1:0]  slot_ff, probe_ff, ft_ff;
   logic           ftv_ff;
   logic [CW-1:0]  entry_ff, slot_q;
   logic [63:0]    rec_q;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   hash_req_type   hreq;
   logic           h_done;
   logic [SW-1:0]  h_home;

   ithi_home #(.SLOTS(SLOTS)) u_home (
      .clock(clock), .reset(reset), .hreq(hreq), .done(h_done), .home(h_home)
   );

   logic accept, bad_cmd, rec_ok;
   logic is_empty, is_tomb, match, last, ftv_now, done_probe;
   logic [SW-1:0] ft_now, slot_next;
   logic [NW-1:0] live_dec;
   logic [NW:0]   tomb_inc;
   logic rb_cond, rb_last, rb_use, clr_last;

   always_comb begin
      accept     = start && (state_ff == ST_IDLE);
      rec_ok     = 32'(req_item.record_slot) < RECORDS;
      bad_cmd    = (req_item.task_id == 64'd0) ||
                   !((req_item.cmd == CMD_LOOKUP) || (req_item.cmd == CMD_REMOVE) ||
                     ((req_item.cmd == CMD_INSERT) && rec_ok));
      is_empty   = entry_ff == CODE_EMPTY;
      is_tomb    = entry_ff == CODE_TOMB;
      match      = !is_empty && !is_tomb && (rec_q == key_ff);
      last       = probe_ff == SW'(SLOTS - 1);
      ftv_now    = ftv_ff || is_tomb;
      ft_now     = ftv_ff ? ft_ff : slot_ff;
      done_probe = match || is_empty || last;
      slot_next  = (slot_ff == SW'(SLOTS - 1)) ? '0 : slot_ff + SW'(1);
      live_dec   = (live_ff != '0) ? live_ff - NW'(1) : '0;
      tomb_inc   = (NW+1)'(tomb_ff) + (NW+1)'(1);
      rb_cond    = (tomb_inc > (NW+1)'(live_dec)) && (tomb_inc >= (NW+1)'(QUARTER));
      rb_last    = rb_idx_ff == RW'(RECORDS - 1);
      rb_use     = (rec_q != 64'd0) && (rec_q != retired_ff);
      clr_last   = clr_idx_ff == CLW'(CLR_N - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_to_rb_ff ? ST_RB_RD : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = bad_cmd ? ST_FAIL : ST_HASH;
            end
         end
         ST_FAIL:    state_in = ST_IDLE;
         ST_HASH: begin
            if (h_done) begin
               state_in = ST_RD_SLOT;
            end
         end
         ST_RD_SLOT: state_in = ST_RD_REC;
         ST_RD_REC:  state_in = ST_EVAL;
         ST_EVAL: begin
            if (!done_probe) begin
               state_in = ST_RD_SLOT;
            end else begin
               unique case (op_ff)
                  OP_REMOVE: state_in = (match && ((live_dec == '0) || rb_cond)) ?
                                        ST_CLEAR : ST_IDLE;
                  OP_REBIND: state_in = rb_last ? ST_IDLE : ST_RB_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_RB_RD:   state_in = ST_RB_CHK;
         ST_RB_CHK: begin
            if (rb_use) begin
               state_in = ST_HASH;
            end else begin
               state_in = rb_last ? ST_IDLE : ST_RB_RD;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and memory controls
   logic          s_we, r_we, s_re, r_re, rsp_fire, rsp_ok;
   logic [SW-1:0] s_waddr, s_raddr;
   logic [CW-1:0] s_wdata;
   logic [RW-1:0] r_waddr, r_raddr;
   logic [63:0]   r_wdata;
   logic [6:0]    rsp_idx;

   always_comb begin
      busy     = state_ff != ST_IDLE;
      s_we     = 1'b0;
      s_waddr  = slot_ff;
      s_wdata  = CODE_EMPTY;
      s_re     = 1'b0;
      s_raddr  = slot_ff;
      r_we     = 1'b0;
      r_waddr  = RW'(req_item.record_slot);
      r_wdata  = req_item.task_id;
      r_re     = 1'b0;
      r_raddr  = rb_idx_ff;
      rsp_fire = 1'b0;
      rsp_ok   = 1'b0;
      rsp_idx  = '0;
      hreq.go  = 1'b0;
      hreq.key = req_item.task_id;
      unique case (state_ff)
         ST_CLEAR: begin
            s_we    = 32'(clr_idx_ff) < SLOTS;
            s_waddr = SW'(clr_idx_ff);
            r_we    = clr_rec_ff && (32'(clr_idx_ff) < RECORDS);
            r_waddr = RW'(clr_idx_ff);
            r_wdata = 64'd0;
         end
         ST_IDLE: begin
            hreq.go = start && !bad_cmd;
            r_we    = start && !bad_cmd && (req_item.cmd == CMD_INSERT);
         end
         ST_FAIL: begin
            rsp_fire = 1'b1;
         end
         ST_RD_SLOT: begin
            s_re = 1'b1;
         end
         ST_RD_REC: begin
            r_re    = 1'b1;
            r_raddr = RW'(slot_q - CW'(1));
         end
         ST_EVAL: begin
            if (done_probe) begin
               unique case (op_ff)
                  OP_LOOKUP: begin
                     rsp_fire = 1'b1;
                     rsp_ok   = match;
                     rsp_idx  = match ? 7'(entry_ff - CW'(1)) : '0;
                  end
                  OP_REMOVE: begin
                     rsp_fire = 1'b1;
                     rsp_ok   = match;
                     s_we     = match;
                     s_wdata  = CODE_TOMB;
                  end
                  default: begin
                     rsp_fire = op_ff == OP_INSERT;
                     rsp_ok   = match || is_empty || ftv_now;
                     s_we     = match || is_empty || ftv_now;
                     s_waddr  = match ? slot_ff : ft_now;
                     s_wdata  = CW'(code_ff) + CW'(1);
                  end
               endcase
            end
         end
         ST_RB_RD: begin
            r_re = 1'b1;
         end
         ST_RB_CHK: begin
            hreq.go  = rb_use;
            hreq.key = rec_q;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         slot_mem[s_waddr] <= s_wdata;
      end
      if (s_re) begin
         slot_q <= slot_mem[s_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         rec_mem[r_waddr] <= r_wdata;
      end
      if (r_re) begin
         rec_q <= rec_mem[r_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         clr_rec_ff   <= 1'b1;
         clr_to_rb_ff <= 1'b0;
         live_ff      <= '0;
         tomb_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_fire;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_last ? '0 : clr_idx_ff + CLW'(1);
            if (clr_last) begin
               clr_rec_ff <= 1'b0;
            end
         end
         if ((state_ff == ST_EVAL) && done_probe) begin
            if (op_ff == OP_REMOVE && match) begin
               if ((live_dec == '0) || rb_cond) begin
                  live_ff      <= '0;
                  tomb_ff      <= '0;
                  clr_to_rb_ff <= (live_dec != '0);
               end else begin
                  live_ff <= live_dec;
                  tomb_ff <= NW'(tomb_inc);
               end
            end else if ((op_ff == OP_INSERT || op_ff == OP_REBIND) && !match &&
                         (is_empty || ftv_now)) begin
               live_ff <= live_ff + NW'(1);
               if (ftv_now && tomb_ff != '0) begin
                  tomb_ff <= tomb_ff - NW'(1);
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_ff.ok          <= rsp_ok;
         rsp_ff.found_index <= rsp_idx;
      end
      if (state_ff == ST_RD_REC) begin
         entry_ff <= slot_q;
      end
      if (accept) begin
         key_ff  <= req_item.task_id;
         code_ff <= RW'(req_item.record_slot);
         unique case (req_item.cmd)
            CMD_INSERT: op_ff <= OP_INSERT;
            CMD_REMOVE: op_ff <= OP_REMOVE;
            default:    op_ff <= OP_LOOKUP;
         endcase
      end
      if (state_ff == ST_RB_CHK && rb_use) begin
         key_ff  <= rec_q;
         code_ff <= rb_idx_ff;
         op_ff   <= OP_REBIND;
      end
      if (state_ff == ST_HASH && h_done) begin
         slot_ff  <= h_home;
         probe_ff <= '0;
         ftv_ff   <= 1'b0;
      end
      if (state_ff == ST_EVAL && !done_probe) begin
         slot_ff  <= slot_next;
         probe_ff <= probe_ff + SW'(1);
         if (is_tomb && !ftv_ff) begin
            ftv_ff <= 1'b1;
            ft_ff  <= slot_ff;
         end
      end
      if (state_ff == ST_EVAL && op_ff == OP_REMOVE && match) begin
         retired_ff <= key_ff;
         rb_idx_ff  <= '0;
      end
      if ((state_ff == ST_EVAL && done_probe && op_ff == OP_REBIND) ||
          (state_ff == ST_RB_CHK && !rb_use)) begin
         rb_idx_ff <= rb_idx_ff + RW'(1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ITHI_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ITHI_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `ITHI_ASSERT_IMP(a_fail_index, clock, reset, rsp_valid && !rsp_item.ok,
                    rsp_item.found_index == 7'd0)
   `ITHI_ASSERT_IMP(a_count_bound, clock, reset, state_ff == ST_IDLE,
                    ((NW+1)'(live_ff) + (NW+1)'(tomb_ff)) <= (NW+1)'(SLOTS))

endmodule
